// ===== rtl/core/tcf_pkg.sv =====
// Package: shared constants and types of the tower cluster finder.
`timescale 1ns / 1ps

package tcf_pkg;

  localparam int GRID_SIZE    = 5;
  localparam int CRYSTAL_BITS = 10;
  localparam int NCELLS       = GRID_SIZE * GRID_SIZE;

  localparam int IN_W      = 10;
  localparam int ADDR_W    = $clog2(NCELLS);
  localparam int GRID_W    = 3;
  localparam int STRIP_W   = 13;
  localparam int TOWER_W   = 15;
  localparam int CLUSTER_W = 14;
  localparam int ACC_W     = 18;
  localparam int STEP_W    = 4;

  localparam int CLUS_STEPS = 9;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_TOTAL = 6'b000010,
    S_WSUM  = 6'b000100,
    S_PEAK  = 6'b001000,
    S_CLUS  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // weighted strip term for bin k (weights ~0.5, 1.5, 2.5, 3.5, 4.5)
  function automatic logic [ACC_W-1:0] strip_term(input logic [STRIP_W-1:0] s,
                                                  input logic [GRID_W-1:0] k);
    logic [ACC_W-1:0] sx;
    logic [ACC_W-1:0] half;
    logic [ACC_W-1:0] res;
    sx   = ACC_W'(s);
    half = ACC_W'(s >> 1);
    case (k)
      3'd0:    res = half;
      3'd1:    res = sx + half;
      3'd2:    res = (sx << 1) + half;
      3'd3:    res = (sx << 2) - half;
      default: res = (sx << 2) + half;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/tcf_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module tcf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/tower_cluster_finder_unit.sv =====
// Top level: 5x5 calorimeter tower 3x3 cluster finder.
//
// Input channel (in_valid/in_ready, crystal_energy): one crystal word per
// cycle, eta-major then phi order, 25 words per tower. in_ready is high
// while the tower is loading and low while a tower is being evaluated.
// Output channel (out_valid/out_ready): one word per tower with eta_bin,
// phi_bin, tower_energy and cluster_energy, held in an output register.
// After the 25th crystal the evaluation runs on one shared accumulator:
// tower sum, per axis a weighted sum and a peak compare that stops at
// the first passing bin, a 3x3 walk over the crystal RAM, and a post of
// the result. No crystal of the next tower is taken before that post.
// The result waits in the output register while loading of the next tower
// goes on; if the previous word is still not taken when the next one is
// ready, the block holds in its post state until out_ready.
// Reset (rst, synchronous) empties the tower, clears the strip sums and
// drops out_valid.
`timescale 1ns / 1ps

module tower_cluster_finder_unit
  import tcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_W-1:0]      crystal_energy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           eta_bin,
  output logic [2:0]           phi_bin,
  output logic [TOWER_W-1:0]   tower_energy,
  output logic [CLUSTER_W-1:0] cluster_energy
);

  state_t state;

  logic [STRIP_W-1:0] eta_sum [GRID_SIZE];
  logic [STRIP_W-1:0] phi_sum [GRID_SIZE];

  logic [ADDR_W-1:0]  load_addr;
  logic [GRID_W-1:0]  load_eta;
  logic [GRID_W-1:0]  load_phi;
  logic [STEP_W-1:0]  cnt;
  logic               axis;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   wsum;
  logic [TOWER_W-1:0] total;
  logic [GRID_W-1:0]  pe;
  logic [GRID_W-1:0]  pp;
  logic [1:0]         dr;
  logic [1:0]         dc;
  logic               rd_ok;

  logic                    in_fire;
  logic                    emit_fire;
  logic [CRYSTAL_BITS-1:0] e;
  logic [STRIP_W-1:0]      strip;
  logic [ACC_W-1:0]        operand;
  logic [ACC_W-1:0]        acc_sum;
  logic [3:0]              rr;
  logic [3:0]              cc;
  logic [3:0]              row;
  logic [3:0]              col;
  logic                    in_grid;
  logic [ADDR_W-1:0]       clus_addr;
  logic [ADDR_W-1:0]       ram_addr;
  logic [CRYSTAL_BITS-1:0] ram_rdata;

  assign in_ready  = (state == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);
  assign e         = crystal_energy[CRYSTAL_BITS-1:0];

  assign strip = axis ? phi_sum[cnt[GRID_W-1:0]] : eta_sum[cnt[GRID_W-1:0]];

  // 3x3 window position, one step off the peak on each side
  assign rr        = {1'b0, pe} + {2'b00, dr};
  assign cc        = {1'b0, pp} + {2'b00, dc};
  assign row       = rr - 4'd1;
  assign col       = cc - 4'd1;
  assign in_grid   = (rr >= 4'd1) && (rr <= 4'(GRID_SIZE)) &&
                     (cc >= 4'd1) && (cc <= 4'(GRID_SIZE));
  assign clus_addr = ADDR_W'(row[GRID_W-1:0]) * ADDR_W'(GRID_SIZE) +
                     ADDR_W'(col[GRID_W-1:0]);
  assign ram_addr  = (state == S_CLUS) ? clus_addr : load_addr;

  always_comb begin
    case (state)
      S_TOTAL: operand = ACC_W'(strip);
      S_WSUM:  operand = strip_term(strip, cnt[GRID_W-1:0]);
      S_PEAK:  operand = ACC_W'(total);
      S_CLUS:  operand = ((cnt != '0) && rd_ok) ? ACC_W'(ram_rdata) : '0;
      default: operand = '0;
    endcase
  end

  assign acc_sum = acc + operand;

  tcf_ram #(
    .WIDTH(CRYSTAL_BITS),
    .DEPTH(NCELLS)
  ) u_store (
    .clk  (clk),
    .we   (in_fire),
    .addr (ram_addr),
    .wdata(e),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      load_addr <= '0;
      load_eta  <= '0;
      load_phi  <= '0;
      cnt       <= '0;
      axis      <= 1'b0;
      acc       <= '0;
      dr        <= '0;
      dc        <= '0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < GRID_SIZE; i++) begin
        eta_sum[i] <= '0;
        phi_sum[i] <= '0;
      end
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (in_fire) begin
            eta_sum[load_eta] <= eta_sum[load_eta] + STRIP_W'(e);
            phi_sum[load_phi] <= phi_sum[load_phi] + STRIP_W'(e);
            if (load_addr == ADDR_W'(NCELLS - 1)) begin
              load_addr <= '0;
              load_eta  <= '0;
              load_phi  <= '0;
              cnt       <= '0;
              axis      <= 1'b0;
              acc       <= '0;
              state     <= S_TOTAL;
            end else begin
              load_addr <= load_addr + ADDR_W'(1);
              if (load_phi == GRID_W'(GRID_SIZE - 1)) begin
                load_phi <= '0;
                load_eta <= load_eta + GRID_W'(1);
              end else begin
                load_phi <= load_phi + GRID_W'(1);
              end
            end
          end
        end
        S_TOTAL: begin
          if (cnt == STEP_W'(GRID_SIZE - 1)) begin
            total <= acc_sum[TOWER_W-1:0];
            acc   <= '0;
            cnt   <= '0;
            state <= S_WSUM;
          end else begin
            acc <= acc_sum;
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_WSUM: begin
          if (cnt == STEP_W'(GRID_SIZE - 1)) begin
            wsum  <= acc_sum;
            acc   <= ACC_W'(total);
            cnt   <= '0;
            state <= S_PEAK;
          end else begin
            acc <= acc_sum;
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_PEAK: begin
          // acc holds (k+1)*T for k = cnt
          if ((wsum <= acc) || (cnt == STEP_W'(GRID_SIZE - 1))) begin
            acc <= '0;
            cnt <= '0;
            if (axis) begin
              pp    <= cnt[GRID_W-1:0];
              dr    <= '0;
              dc    <= '0;
              rd_ok <= 1'b0;
              state <= S_CLUS;
            end else begin
              pe    <= cnt[GRID_W-1:0];
              axis  <= 1'b1;
              state <= S_WSUM;
            end
          end else begin
            acc <= acc_sum;
            cnt <= cnt + STEP_W'(1);
          end
        end
        S_CLUS: begin
          acc <= acc_sum;
          if (cnt == STEP_W'(CLUS_STEPS)) begin
            state <= S_EMIT;
          end else begin
            cnt   <= cnt + STEP_W'(1);
            rd_ok <= in_grid;
            if (dc == 2'd2) begin
              dc <= '0;
              dr <= dr + 2'd1;
            end else begin
              dc <= dc + 2'd1;
            end
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            eta_bin        <= pe;
            phi_bin        <= pp;
            tower_energy   <= total;
            cluster_energy <= acc[CLUSTER_W-1:0];
            for (int i = 0; i < GRID_SIZE; i++) begin
              eta_sum[i] <= '0;
              phi_sum[i] <= '0;
            end
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench: tower cluster finder, random and directed towers against a peak/cluster predictor.
`timescale 1ns / 1ps

import tcf_pkg::*;

class tower_scoreboard;
  typedef struct {
    logic [GRID_W-1:0]    eta_bin;
    logic [GRID_W-1:0]    phi_bin;
    logic [TOWER_W-1:0]   tower_energy;
    logic [CLUSTER_W-1:0] cluster_energy;
  } tower_word_t;

  logic [CRYSTAL_BITS-1:0]             cells [NCELLS];
  logic [ADDR_W-1:0]                   cell_idx;
  logic [GRID_SIZE-1:0][STRIP_W-1:0]   eta_sum;
  logic [GRID_SIZE-1:0][STRIP_W-1:0]   phi_sum;
  tower_word_t                         expected_words [$];
  int unsigned                         mismatches;

  function new();
    foreach (cells[i]) cells[i] = '0;
    cell_idx   = '0;
    eta_sum    = '0;
    phi_sum    = '0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return expected_words.size();
  endfunction

  task report(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function logic [GRID_W-1:0] peak_bin(input logic [GRID_SIZE-1:0][STRIP_W-1:0] s,
                                       input logic [TOWER_W-1:0] total);
    logic [ACC_W-1:0] w;
    logic [ACC_W-1:0] lim;
    w = ACC_W'(s[0] >> 1)
      + ACC_W'(s[1]) + ACC_W'(s[1] >> 1)
      + (ACC_W'(s[2]) << 1) + ACC_W'(s[2] >> 1)
      + (ACC_W'(s[3]) << 2) - ACC_W'(s[3] >> 1)
      + (ACC_W'(s[4]) << 2) + ACC_W'(s[4] >> 1);
    for (int k = 0; k < GRID_SIZE - 1; k++) begin
      lim = ACC_W'(k + 1) * ACC_W'(total);
      if (w <= lim) return GRID_W'(k);
    end
    return GRID_W'(GRID_SIZE - 1);
  endfunction

  function void note_crystal(input logic [IN_W-1:0] e);
    logic [CRYSTAL_BITS-1:0] v;
    int eta;
    int phi;
    int r;
    int c;
    tower_word_t word;
    v = e[CRYSTAL_BITS-1:0];
    eta = int'(cell_idx) / GRID_SIZE;
    phi = int'(cell_idx) % GRID_SIZE;
    cells[cell_idx] = v;
    eta_sum[eta] = eta_sum[eta] + STRIP_W'(v);
    phi_sum[phi] = phi_sum[phi] + STRIP_W'(v);
    if (int'(cell_idx) < NCELLS - 1) begin
      cell_idx = cell_idx + 1'b1;
      return;
    end
    word.tower_energy = '0;
    for (int i = 0; i < GRID_SIZE; i++)
      word.tower_energy = word.tower_energy + TOWER_W'(eta_sum[i]);
    word.eta_bin = peak_bin(eta_sum, word.tower_energy);
    word.phi_bin = peak_bin(phi_sum, word.tower_energy);
    word.cluster_energy = '0;
    for (int de = -1; de <= 1; de++) begin
      for (int dp = -1; dp <= 1; dp++) begin
        r = int'(word.eta_bin) + de;
        c = int'(word.phi_bin) + dp;
        if (r >= 0 && r < GRID_SIZE && c >= 0 && c < GRID_SIZE)
          word.cluster_energy = word.cluster_energy + CLUSTER_W'(cells[r * GRID_SIZE + c]);
      end
    end
    expected_words.push_back(word);
    cell_idx = '0;
    eta_sum  = '0;
    phi_sum  = '0;
  endfunction

  task check_result(input logic [2:0] pe, input logic [2:0] pp,
                    input logic [TOWER_W-1:0] te, input logic [CLUSTER_W-1:0] ce);
    tower_word_t want;
    if (expected_words.size() == 0) begin
      report("unexpected word, tower_energy", te, 0);
      return;
    end
    want = expected_words.pop_front();
    if (pe !== want.eta_bin)        report("eta_bin", pe, want.eta_bin);
    if (pp !== want.phi_bin)        report("phi_bin", pp, want.phi_bin);
    if (te !== want.tower_energy)   report("tower_energy", te, want.tower_energy);
    if (ce !== want.cluster_energy) report("cluster_energy", ce, want.cluster_energy);
  endtask
endclass

module testbench;
  localparam int RANDOM_TOWERS  = 40;
  localparam int QUIET_TOWERS   = 6;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [IN_W-1:0]      crystal_energy;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           eta_bin;
  logic [2:0]           phi_bin;
  logic [TOWER_W-1:0]   tower_energy;
  logic [CLUSTER_W-1:0] cluster_energy;

  tower_scoreboard sb = new();

  logic [IN_W-1:0] tower_cells [NCELLS];
  bit              quiet = 1'b0;
  bit              long_hold = 1'b0;
  bit              hold_done = 1'b0;
  int unsigned     idle_cycles;

  tower_cluster_finder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .crystal_energy (crystal_energy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .eta_bin        (eta_bin),
    .phi_bin        (phi_bin),
    .tower_energy   (tower_energy),
    .cluster_energy (cluster_energy)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted words and the no-progress watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_crystal(crystal_energy);
      if (out_valid && out_ready)
        sb.check_result(eta_bin, phi_bin, tower_energy, cluster_energy);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_crystal(input logic [IN_W-1:0] e);
    in_valid       <= 1'b1;
    crystal_energy <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid       <= 1'b0;
      crystal_energy <= IN_W'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_tower();
    for (int i = 0; i < NCELLS; i++) send_crystal(tower_cells[i]);
  endtask

  task automatic fill_tower(input logic [IN_W-1:0] v);
    foreach (tower_cells[i]) tower_cells[i] = v;
  endtask

  task automatic build_random_tower();
    int mode;
    int hr;
    int hc;
    int r;
    int c;
    mode = $urandom_range(0, 3);
    hr   = $urandom_range(0, GRID_SIZE - 1);
    hc   = $urandom_range(0, GRID_SIZE - 1);
    for (int i = 0; i < NCELLS; i++) begin
      r = i / GRID_SIZE;
      c = i % GRID_SIZE;
      case (mode)
        0: tower_cells[i] = IN_W'($urandom_range(0, 1023));
        1: tower_cells[i] = (r == hr && c == hc) ? IN_W'(1023) : IN_W'($urandom_range(0, 15));
        2: tower_cells[i] = (r >= hr - 1 && r <= hr + 1 && c >= hc - 1 && c <= hc + 1) ?
                            IN_W'($urandom_range(256, 1023)) : IN_W'($urandom_range(0, 31));
        default: tower_cells[i] = $urandom_range(0, 1) ? IN_W'(1023) : IN_W'(0);
      endcase
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    crystal_energy = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty tower, full-scale tower, alternating bit patterns
    fill_tower('0);
    send_tower();
    fill_tower(IN_W'(1023));
    send_tower();
    foreach (tower_cells[i]) tower_cells[i] = i[0] ? IN_W'(10'h2AA) : IN_W'(10'h155);
    send_tower();
    // single hot crystal in opposite corners: peak on the grid edge, clipped 3x3
    fill_tower('0);
    tower_cells[0] = IN_W'(1023);
    send_tower();
    fill_tower('0);
    tower_cells[NCELLS-1] = IN_W'(1023);
    send_tower();

    for (int t = 0; t < RANDOM_TOWERS; t++) begin
      if (t == 8) long_hold = 1'b1;
      if (t == RANDOM_TOWERS - QUIET_TOWERS) quiet = 1'b1;
      build_random_tower();
      send_tower();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
